[hdl/poac_pkg.sv]
// Shared types and constants for the path ORAM access controller.
`timescale 1ns / 1ps
package poac_pkg;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_NEW  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  blk_id;
    logic [63:0] write_data;
    logic [3:0]  fresh_leaf;
  } req_t;

  typedef struct packed {
    logic [63:0] prev_data;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH_CHK,
    S_FETCH_WR,
    S_LOOK_RD,
    S_LOOK_CMP,
    S_UPDATE,
    S_EV_RD,
    S_EV_PROC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic fetch_read;
    logic fetch_push;
    logic fetch_adv;
    logic look_read;
    logic look_hit;
    logic look_next;
    logic update;
    logic ev_read;
    logic ev_end_level;
    logic ev_proc;
  } cmd_t;

  typedef struct packed {
    logic slot_valid;
    logic fetch_last;
    logic look_end;
    logic look_match;
    logic ev_end;
    logic level_zero;
  } sts_t;

endpackage

[hdl/poac_ctrl.sv]
// Sequencing state machine for the path ORAM access controller.
`timescale 1ns / 1ps
module poac_ctrl
  import poac_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  sts_t   sts,
  output cmd_t   cmd,
  output logic   busy,
  output logic   done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_FETCH_CHK;
      end
      S_FETCH_CHK: begin
        if (sts.slot_valid) state_next = S_FETCH_WR;
        else if (sts.fetch_last) state_next = S_LOOK_RD;
      end
      S_FETCH_WR: begin
        state_next = sts.fetch_last ? S_LOOK_RD : S_FETCH_CHK;
      end
      S_LOOK_RD: begin
        state_next = sts.look_end ? S_UPDATE : S_LOOK_CMP;
      end
      S_LOOK_CMP: begin
        state_next = sts.look_match ? S_UPDATE : S_LOOK_RD;
      end
      S_UPDATE: state_next = S_EV_RD;
      S_EV_RD: begin
        if (!sts.ev_end) state_next = S_EV_PROC;
        else if (sts.level_zero) state_next = S_DONE;
      end
      S_EV_PROC: state_next = S_EV_RD;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_FETCH_CHK: begin
        cmd.fetch_read = sts.slot_valid;
        cmd.fetch_adv  = !sts.slot_valid;
      end
      S_FETCH_WR: begin
        cmd.fetch_push = 1'b1;
        cmd.fetch_adv  = 1'b1;
      end
      S_LOOK_RD: cmd.look_read = !sts.look_end;
      S_LOOK_CMP: begin
        cmd.look_hit  = sts.look_match;
        cmd.look_next = !sts.look_match;
      end
      S_UPDATE: cmd.update = 1'b1;
      S_EV_RD: begin
        cmd.ev_read      = !sts.ev_end;
        cmd.ev_end_level = sts.ev_end;
      end
      S_EV_PROC: cmd.ev_proc = 1'b1;
      S_DONE: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

[hdl/poac_datapath.sv]
// Position map, bucket tree, stash and request registers of the path ORAM controller.
`timescale 1ns / 1ps
module poac_datapath
  import poac_pkg::*;
#(
  parameter int TREE_HEIGHT  = 4,
  parameter int BUCKET_SLOTS = 4,
  parameter int STASH_DEPTH  = 64,
  parameter int DATA_WIDTH   = 64
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  localparam int LW  = TREE_HEIGHT;
  localparam int NB  = (2 << TREE_HEIGHT) - 1;
  localparam int TS  = NB * BUCKET_SLOTS;
  localparam int TAW = $clog2(TS);
  localparam int BKW = TREE_HEIGHT + 1;
  localparam int SAW = $clog2(STASH_DEPTH);
  localparam int SCW = $clog2(STASH_DEPTH + 1);
  localparam int LVW = $clog2(TREE_HEIGHT + 1);
  localparam int FW  = $clog2(BUCKET_SLOTS + 1);
  localparam int SW  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int EW  = 4 + LW + DATA_WIDTH;

  logic [EW-1:0] tree_mem [TS];
  logic [EW-1:0] stash_mem [STASH_DEPTH];
  logic [TS-1:0] tree_valid;
  logic [LW-1:0] pmap [16];

  logic                  r_type;
  logic [3:0]            r_id;
  logic [DATA_WIDTH-1:0] r_wdata;
  logic [LW-1:0]         new_leaf;
  logic [LW-1:0]         old_leaf;
  logic [LVW-1:0]        level;
  logic [SW-1:0]         slot;
  logic [FW-1:0]         filled;
  logic [SCW-1:0]        rp;
  logic [SCW-1:0]        wp;
  logic [SCW-1:0]        count;
  logic                  found;
  logic [SAW-1:0]        found_idx;
  logic [DATA_WIDTH-1:0] prev_data;
  logic                  overflow;
  logic [EW-1:0]         tree_q;
  logic [EW-1:0]         stash_q;

  logic [LVW-1:0]        shamt;
  logic [BKW-1:0]        lvl_first;
  logic [BKW-1:0]        path_bucket;
  logic [TAW-1:0]        fetch_addr;
  logic [TAW-1:0]        fill_addr;
  logic                  ev_match;
  logic                  ev_take;
  logic                  push;
  logic                  full;
  logic [EW-1:0]         push_entry;
  logic                  st_we;
  logic [SAW-1:0]        st_waddr;
  logic [EW-1:0]         st_wdata;

  assign shamt       = LVW'(TREE_HEIGHT) - level;
  assign lvl_first   = (BKW'(1) << level) - BKW'(1);
  assign path_bucket = lvl_first + BKW'(old_leaf >> shamt);
  assign fetch_addr  = TAW'(path_bucket * BUCKET_SLOTS) + TAW'(slot);
  assign fill_addr   = TAW'(path_bucket * BUCKET_SLOTS) + TAW'(filled);
  assign ev_match    = (stash_q[DATA_WIDTH +: LW] >> shamt) == (old_leaf >> shamt);
  assign ev_take     = ev_match && (filled < FW'(BUCKET_SLOTS));
  assign full        = count >= SCW'(STASH_DEPTH);

  assign sts.slot_valid = tree_valid[fetch_addr];
  assign sts.fetch_last = (slot == SW'(BUCKET_SLOTS - 1)) && (level == LVW'(TREE_HEIGHT));
  assign sts.look_end   = rp == count;
  assign sts.look_match = stash_q[EW-1 -: 4] == r_id;
  assign sts.ev_end     = rp == count;
  assign sts.level_zero = level == '0;

  always_comb begin
    push       = 1'b0;
    push_entry = tree_q;
    st_we      = 1'b0;
    st_waddr   = count[SAW-1:0];
    st_wdata   = tree_q;
    if (cmd.fetch_push) begin
      push = 1'b1;
    end else if (cmd.update && found) begin
      st_we    = 1'b1;
      st_waddr = found_idx;
      st_wdata = {r_id, new_leaf, r_type ? r_wdata : stash_q[DATA_WIDTH-1:0]};
    end else if (cmd.update && r_type) begin
      push       = 1'b1;
      push_entry = {r_id, new_leaf, r_wdata};
    end else if (cmd.ev_proc && !ev_take) begin
      st_we    = 1'b1;
      st_waddr = wp[SAW-1:0];
      st_wdata = stash_q;
    end
    if (push && !full) begin
      st_we    = 1'b1;
      st_waddr = count[SAW-1:0];
      st_wdata = push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) stash_mem[st_waddr] <= st_wdata;
    if (cmd.look_read || cmd.ev_read) stash_q <= stash_mem[rp[SAW-1:0]];
    if (cmd.fetch_read) tree_q <= tree_mem[fetch_addr];
    if (cmd.ev_proc && ev_take) tree_mem[fill_addr] <= stash_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_valid <= '0;
      for (int i = 0; i < 16; i++) pmap[i] <= '0;
      count <= '0;
    end else begin
      if (cmd.load) pmap[req.blk_id] <= LW'(req.fresh_leaf);
      if (cmd.fetch_read) tree_valid[fetch_addr] <= 1'b0;
      if (cmd.ev_proc && ev_take) tree_valid[fill_addr] <= 1'b1;
      if (push && !full) count <= count + SCW'(1);
      if (cmd.ev_end_level) count <= wp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_type    <= req.req_type;
      r_id      <= req.blk_id;
      r_wdata   <= DATA_WIDTH'(req.write_data);
      new_leaf  <= LW'(req.fresh_leaf);
      old_leaf  <= pmap[req.blk_id];
      level     <= '0;
      slot      <= '0;
      rp        <= '0;
      found     <= 1'b0;
      prev_data <= '0;
      overflow  <= 1'b0;
    end
    if (push && full) overflow <= 1'b1;
    if (cmd.fetch_adv) begin
      if (slot == SW'(BUCKET_SLOTS - 1)) begin
        slot <= '0;
        if (level != LVW'(TREE_HEIGHT)) level <= level + LVW'(1);
      end else begin
        slot <= slot + SW'(1);
      end
    end
    if (cmd.look_hit) begin
      found     <= 1'b1;
      found_idx <= rp[SAW-1:0];
      prev_data <= stash_q[DATA_WIDTH-1:0];
    end
    if (cmd.look_next) rp <= rp + SCW'(1);
    if (cmd.update) begin
      level  <= LVW'(TREE_HEIGHT);
      rp     <= '0;
      wp     <= '0;
      filled <= '0;
    end
    if (cmd.ev_end_level) begin
      if (level != '0) level <= level - LVW'(1);
      rp     <= '0;
      wp     <= '0;
      filled <= '0;
    end
    if (cmd.ev_proc) begin
      rp <= rp + SCW'(1);
      if (ev_take) filled <= filled + FW'(1);
      else wp <= wp + SCW'(1);
    end
  end

  assign rsp.prev_data = 64'(prev_data);
  assign rsp.status    = overflow ? ST_OVF : found ? ST_HIT : r_type ? ST_NEW : ST_MISS;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= SCW'(STASH_DEPTH))
    else $error("stash count beyond depth");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    cmd.ev_proc |-> wp <= rp)
    else $error("stash write pointer passed read pointer");

  a_bucket_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.ev_proc |-> filled <= FW'(BUCKET_SLOTS))
    else $error("bucket overfilled");

  a_ev_step: assert property (@(posedge clk) disable iff (rst)
    cmd.ev_proc |=> rp == $past(rp) + SCW'(1))
    else $error("eviction scan did not advance");

endmodule

[hdl/path_oram_access_controller.sv]
// Top level of the path ORAM access controller.
//
//   channel   ports             handshake
//   request   req (req_t)       taken when start is high and busy is low
//   response  rsp (rsp_t)       valid for the one cycle that done is high
//
// A request fetches the valid blocks on its path into the stash, compares stash entries
// until the block is found or the stash ends, updates the block in the stash or adds it
// on a write miss, and then scans the whole stash once per eviction level, leaf to root.
// Reset clears the position map, tree valid bits and stash count.
// The receiver cannot stall; busy stays high until done has been shown.
`timescale 1ns / 1ps
module path_oram_access_controller
  import poac_pkg::*;
#(
  parameter int TREE_HEIGHT  = 4,
  parameter int BUCKET_SLOTS = 4,
  parameter int STASH_DEPTH  = 64,
  parameter int DATA_WIDTH   = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  poac_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  poac_datapath #(
    .TREE_HEIGHT  (TREE_HEIGHT),
    .BUCKET_SLOTS (BUCKET_SLOTS),
    .STASH_DEPTH  (STASH_DEPTH),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

[tb/poac_checker.sv]
// Checker for the path ORAM access controller: predicts and compares every response.
`timescale 1ns / 1ps
module poac_checker
  import poac_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  localparam int HEIGHT  = 4;
  localparam int SLOTS   = 4;
  localparam int DEPTH   = 64;
  localparam int BUCKETS = (2 << HEIGHT) - 1;

  logic [3:0]  pos_map [16];
  logic        slot_vld [BUCKETS*SLOTS];
  logic [3:0]  slot_id [BUCKETS*SLOTS];
  logic [3:0]  slot_leaf [BUCKETS*SLOTS];
  logic [63:0] slot_data [BUCKETS*SLOTS];
  logic [3:0]  st_id [DEPTH];
  logic [3:0]  st_leaf [DEPTH];
  logic [63:0] st_data [DEPTH];
  int          st_cnt;
  bit          ovf;
  rsp_t        rsp_q[$];

  function automatic int bucket_of(logic [3:0] leaf, int lvl);
    return ((1 << lvl) - 1) + (int'(leaf) >> (HEIGHT - lvl));
  endfunction

  function automatic void stash_add(logic [3:0] id, logic [3:0] leaf, logic [63:0] d);
    if (st_cnt >= DEPTH) begin
      ovf = 1;
    end else begin
      st_id[st_cnt] = id;
      st_leaf[st_cnt] = leaf;
      st_data[st_cnt] = d;
      st_cnt++;
    end
  endfunction

  function automatic void stash_remove(int idx);
    for (int k = idx; k + 1 < st_cnt; k++) begin
      st_id[k] = st_id[k+1];
      st_leaf[k] = st_leaf[k+1];
      st_data[k] = st_data[k+1];
    end
    st_cnt--;
  endfunction

  function automatic rsp_t access(req_t r);
    rsp_t res;
    logic [3:0] old_leaf;
    int hit;
    int base;
    int bkt;
    int filled;
    int i;
    ovf = 0;
    hit = -1;
    old_leaf = pos_map[r.blk_id];
    pos_map[r.blk_id] = r.fresh_leaf;
    for (int lv = 0; lv <= HEIGHT; lv++) begin
      base = bucket_of(old_leaf, lv) * SLOTS;
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_vld[base+s]) begin
          stash_add(slot_id[base+s], slot_leaf[base+s], slot_data[base+s]);
          slot_vld[base+s] = 0;
        end
      end
    end
    for (int k = 0; k < st_cnt; k++) begin
      if (hit < 0 && st_id[k] == r.blk_id) hit = k;
    end
    res.prev_data = '0;
    if (hit >= 0) begin
      res.prev_data = st_data[hit];
      st_leaf[hit] = r.fresh_leaf;
      if (r.req_type) st_data[hit] = r.write_data;
      res.status = ST_HIT;
    end else if (r.req_type) begin
      stash_add(r.blk_id, r.fresh_leaf, r.write_data);
      res.status = ST_NEW;
    end else begin
      res.status = ST_MISS;
    end
    for (int lv = HEIGHT; lv >= 0; lv--) begin
      bkt = bucket_of(old_leaf, lv);
      base = bkt * SLOTS;
      filled = 0;
      i = 0;
      while (i < st_cnt && filled < SLOTS) begin
        if (bucket_of(st_leaf[i], lv) == bkt) begin
          slot_vld[base+filled] = 1;
          slot_id[base+filled] = st_id[i];
          slot_leaf[base+filled] = st_leaf[i];
          slot_data[base+filled] = st_data[i];
          filled++;
          stash_remove(i);
        end else begin
          i++;
        end
      end
    end
    if (ovf) res.status = ST_OVF;
    return res;
  endfunction

  rsp_t exp_rsp;

  always @(posedge clk) begin
    if (rst) begin
      foreach (pos_map[k]) pos_map[k] = '0;
      foreach (slot_vld[k]) slot_vld[k] = 0;
      st_cnt = 0;
      rsp_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (done) begin
        if (rsp_q.size() == 0) begin
          $display("%0t: unexpected response prev_data=%h status=%0d",
                   $time, rsp.prev_data, rsp.status);
          fail_count <= fail_count + 1;
        end else begin
          exp_rsp = rsp_q.pop_front();
          if (exp_rsp.prev_data !== rsp.prev_data || exp_rsp.status !== rsp.status) begin
            $display("%0t: mismatch expected prev_data=%h status=%0d",
                     $time, exp_rsp.prev_data, exp_rsp.status,
                     " actual prev_data=%h status=%0d", rsp.prev_data, rsp.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) rsp_q.push_back(access(req));
      pending <= rsp_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the path ORAM access controller: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top
  import poac_pkg::*;
;

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   issued;

  path_oram_access_controller dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  poac_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("path_oram_access_controller verification failed");
      $finish;
    end
  end

  // Hold the request until it is taken, then drop start.
  task automatic send(logic rw, logic [3:0] id, logic [63:0] d, logic [3:0] leaf);
    @(negedge clk);
    start <= 1;
    req <= '{req_type: rw, blk_id: id, write_data: d, fresh_leaf: leaf};
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
    @(negedge clk);
    start <= 0;
  endtask

  task automatic rand_gap(bit quiet);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  function automatic logic [63:0] rand_data();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [3:0] id_set;
    issued = 0;
    start = 0;
    req = '0;
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(0, 4'd0, '0, 4'd0);
    send(1, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    send(0, 4'd0, '0, 4'd0);
    send(1, 4'd15, 64'h8000_0000_0000_0001, 4'd15);
    send(1, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd0);
    send(0, 4'd15, '1, 4'd8);
    send(0, 4'd7, 64'h5555_5555_5555_5555, 4'd7);
    for (int k = 0; k < 16; k++) send(1, k[3:0], {$urandom, $urandom}, 4'd5);

    // Drain fully once before the random part.
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    for (int n = 0; n < 1650; n++) begin
      id_set = (n < 600) ? {2'b00, 2'($urandom)} : 4'($urandom);
      send($urandom_range(0, 2) != 0, (n % 200 < 100) ? id_set : 4'($urandom),
           rand_data(), (n % 300 < 60) ? 4'd3 : 4'($urandom));
      rand_gap(n > 1400);
    end

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("path_oram_access_controller verification clean");
    end else begin
      $display("path_oram_access_controller verification failed");
    end
    $finish;
  end

endmodule
